// ===== rtl/erf_pkg.sv =====
package erf_pkg;

  // Record framing constants
  localparam logic [5:0]  MaxPayload  = 6'd43;
  localparam logic [15:0] HeaderExtra = 16'd17;
  localparam logic [15:0] CrcPoly     = 16'hA001;
  localparam logic [7:0]  MagicD      = 8'h44;
  localparam logic [7:0]  Magic0      = 8'h30;
  localparam logic [7:0]  StatusByte  = 8'h00;

  // Input action codes
  localparam logic ActHeader  = 1'b0;
  localparam logic ActPayload = 1'b1;

  // Register index of start_event_id
  localparam logic RegStartEventId = 1'b0;

  // Byte positions within the back-end sequence
  localparam logic [4:0] HdrLast  = 5'd14;
  localparam logic [4:0] HdrCrcLo = 5'd15;
  localparam logic [4:0] HdrCrcHi = 5'd16;
  localparam logic [4:0] PayData  = 5'd0;
  localparam logic [4:0] PayCrcLo = 5'd1;
  localparam logic [4:0] PayCrcHi = 5'd2;

  typedef enum logic [1:0] {
    CMD_HDR,
    CMD_PAY,
    CMD_OVR
  } cmd_kind_e;

  // One classified item, passed from front to back
  typedef struct packed {
    cmd_kind_e   kind;
    logic        fin;
    logic [5:0]  len;
    logic [7:0]  data;
    logic [31:0] ts;
    logic [31:0] eid;
    logic [15:0] etype;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       record_end;
    logic       overrun;
  } res_t;

  // Front status, observed by the top level
  typedef struct packed {
    logic        in_record;
    logic [31:0] event_counter;
  } front_stat_t;

  // One byte of CRC-16/ARC, reflected
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/event_record_framer_crc16.sv =====
// Channel  | Handshake                        | Payload
// ---------+----------------------------------+------------------------------------------
// input    | push / full                      | action, rec_type, timestamp,
//          |                                  | save_record, payload_length, payload_byte
// result   | empty / pop                      | out_byte, run_last, record_end, overrun
// config   | psel, penable, pwrite, pready    | paddr (index in bit 2), pwdata, prdata
//
// One item enters per cycle while the command queue (CMD_DEPTH entries) has room.
// The back end emits one result byte per cycle unless stalled: a payload item gives
// 1 byte (3 if it closes the record), a header 15 bytes (17 with no payload).
// Reset clears the record state, event counter and both queues; no clearing pass.
// A full result queue stalls the back end; a full command queue raises full.
module event_record_framer_crc16 #(
  parameter int CMD_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        action_i,
  input  logic [15:0] rec_type_i,
  input  logic [31:0] timestamp_i,
  input  logic        save_record_i,
  input  logic [5:0]  payload_length_i,
  input  logic [7:0]  payload_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        record_end_o,
  output logic        overrun_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import erf_pkg::*;

  localparam int ResDepth = 2;

  logic        accept;
  logic        cfg_we;
  logic [31:0] start_id_q;
  cmd_t        front_cmd, back_cmd;
  front_stat_t front_stat;
  logic        cq_empty, cq_pop;
  logic        of_full;
  logic        res_valid;
  res_t        back_res, out_res;

  assign accept = push && !full;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == RegStartEventId);

  // Hold the last written start id for readback
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_id_q <= 32'd0;
    end else if (cfg_we) begin
      start_id_q <= pwdata;
    end
  end

  assign prdata = (paddr[2] == RegStartEventId) ? start_id_q : 32'd0;

  erf_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .action_i         (action_i),
    .rec_type_i       (rec_type_i),
    .timestamp_i      (timestamp_i),
    .save_record_i    (save_record_i),
    .payload_length_i (payload_length_i),
    .payload_byte_i   (payload_byte_i),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (pwdata),
    .cmd_o            (front_cmd),
    .stat_o           (front_stat)
  );

  erf_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .wdata_i (front_cmd),
    .pop_i   (cq_pop),
    .rdata_o (back_cmd),
    .full_o  (full),
    .empty_o (cq_empty)
  );

  erf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cq_empty),
    .cmd_i       (back_cmd),
    .out_ready_i (!of_full),
    .cmd_pop_o   (cq_pop),
    .res_valid_o (res_valid),
    .res_o       (back_res)
  );

  erf_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (ResDepth)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .wdata_i (back_res),
    .pop_i   (pop),
    .rdata_o (out_res),
    .full_o  (of_full),
    .empty_o (empty)
  );

  assign out_byte_o   = out_res.out_byte;
  assign run_last_o   = out_res.run_last;
  assign record_end_o = out_res.record_end;
  assign overrun_o    = out_res.overrun;

`ifndef SYNTH
  // A record always closes the run of its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && record_end_o) |-> run_last_o)
    else $error("record end without run end");

  // A dropped byte gives a single flagged result outside any record end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && overrun_o) |-> (run_last_o && !record_end_o && out_byte_o == 8'h00))
    else $error("malformed overrun result");

  // A start id write loads the event counter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we |=> (front_stat.event_counter == $past(pwdata)))
    else $error("event counter not loaded");

  // A finished header with no payload leaves the record closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && action_i == ActHeader && payload_length_i == 6'd0) |=> !front_stat.in_record)
    else $error("empty record left open");
`endif

endmodule

// ===== rtl/erf_fifo.sv =====
module erf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store the item
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/erf_front.sv =====
module erf_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic                 action_i,
  input  logic [15:0]          rec_type_i,
  input  logic [31:0]          timestamp_i,
  input  logic                 save_record_i,
  input  logic [5:0]           payload_length_i,
  input  logic [7:0]           payload_byte_i,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_wdata_i,
  output erf_pkg::cmd_t        cmd_o,
  output erf_pkg::front_stat_t stat_o
);

  import erf_pkg::*;

  logic        in_rec_q, in_rec_d;
  logic        saved_q, saved_d;
  logic [5:0]  rem_q, rem_d;
  logic [31:0] cnt_q, cnt_d;
  logic [5:0]  plen_sat;

  assign plen_sat = (payload_length_i > MaxPayload) ? MaxPayload : payload_length_i;

  // Classify the item and track the record
  always_comb begin
    in_rec_d = in_rec_q;
    saved_d  = saved_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    cmd_o       = '0;
    cmd_o.kind  = CMD_OVR;
    cmd_o.ts    = timestamp_i;
    cmd_o.etype = rec_type_i;
    if (action_i == ActHeader) begin
      cmd_o.kind = CMD_HDR;
      cmd_o.len  = plen_sat;
      cmd_o.eid  = save_record_i ? cnt_q : 32'd0;
      cmd_o.fin  = (plen_sat == 6'd0);
      if (accept_i) begin
        if (cmd_o.fin) begin
          cnt_d    = cnt_q + {31'd0, save_record_i};
          in_rec_d = 1'b0;
          saved_d  = 1'b0;
          rem_d    = 6'd0;
        end else begin
          in_rec_d = 1'b1;
          saved_d  = save_record_i;
          rem_d    = plen_sat;
        end
      end
    end else if (!in_rec_q || rem_q == 6'd0) begin
      // Drop a byte that no record expects
      cmd_o.kind = CMD_OVR;
    end else begin
      cmd_o.kind = CMD_PAY;
      cmd_o.data = payload_byte_i;
      cmd_o.fin  = (rem_q == 6'd1);
      if (accept_i) begin
        rem_d = rem_q - 6'd1;
        if (cmd_o.fin) begin
          cnt_d    = cnt_q + {31'd0, saved_q};
          in_rec_d = 1'b0;
          saved_d  = 1'b0;
        end
      end
    end
    if (cfg_we_i) begin
      cnt_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_rec_q <= 1'b0;
      saved_q  <= 1'b0;
      rem_q    <= 6'd0;
      cnt_q    <= 32'd0;
    end else begin
      in_rec_q <= in_rec_d;
      saved_q  <= saved_d;
      rem_q    <= rem_d;
      cnt_q    <= cnt_d;
    end
  end

  assign stat_o.in_record     = in_rec_q;
  assign stat_o.event_counter = cnt_q;

endmodule

// ===== rtl/erf_back.sv =====
module erf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  erf_pkg::cmd_t cmd_i,
  input  logic          out_ready_i,
  output logic          cmd_pop_o,
  output logic          res_valid_o,
  output erf_pkg::res_t res_o
);

  import erf_pkg::*;

  logic [4:0]  idx_q;
  logic [15:0] crc_q;
  logic [4:0]  last_idx;
  logic [7:0]  cur_byte;
  logic        rec_byte;
  logic        is_last;
  logic        emit;
  logic [15:0] len16;
  logic [15:0] crc_base;

  assign len16 = {10'd0, cmd_i.len} + HeaderExtra;

  // Pick the byte for the current step
  always_comb begin
    last_idx = '0;
    cur_byte = 8'h00;
    rec_byte = 1'b0;
    case (cmd_i.kind)
      CMD_HDR: begin
        last_idx = cmd_i.fin ? HdrCrcHi : HdrLast;
        rec_byte = (idx_q <= HdrLast);
        case (idx_q)
          5'd0:    cur_byte = MagicD;
          5'd1:    cur_byte = Magic0;
          5'd2:    cur_byte = len16[7:0];
          5'd3:    cur_byte = len16[15:8];
          5'd4:    cur_byte = cmd_i.ts[7:0];
          5'd5:    cur_byte = cmd_i.ts[15:8];
          5'd6:    cur_byte = cmd_i.ts[23:16];
          5'd7:    cur_byte = cmd_i.ts[31:24];
          5'd8:    cur_byte = StatusByte;
          5'd9:    cur_byte = cmd_i.eid[7:0];
          5'd10:   cur_byte = cmd_i.eid[15:8];
          5'd11:   cur_byte = cmd_i.eid[23:16];
          5'd12:   cur_byte = cmd_i.eid[31:24];
          5'd13:   cur_byte = cmd_i.etype[7:0];
          5'd14:   cur_byte = cmd_i.etype[15:8];
          HdrCrcLo: cur_byte = crc_q[7:0];
          HdrCrcHi: cur_byte = crc_q[15:8];
          default: cur_byte = 8'h00;
        endcase
      end
      CMD_PAY: begin
        last_idx = cmd_i.fin ? PayCrcHi : PayData;
        rec_byte = (idx_q == PayData);
        case (idx_q)
          PayData:  cur_byte = cmd_i.data;
          PayCrcLo: cur_byte = crc_q[7:0];
          PayCrcHi: cur_byte = crc_q[15:8];
          default:  cur_byte = 8'h00;
        endcase
      end
      default: begin
        last_idx = '0;
        cur_byte = 8'h00;
      end
    endcase
  end

  // Restart the checksum on the first header byte
  assign crc_base = (cmd_i.kind == CMD_HDR && idx_q == 5'd0) ? 16'h0000 : crc_q;

  assign is_last     = (idx_q == last_idx);
  assign emit        = cmd_valid_i && out_ready_i;
  assign cmd_pop_o   = emit && is_last;
  assign res_valid_o = emit;

  assign res_o.out_byte   = cur_byte;
  assign res_o.run_last   = is_last;
  assign res_o.record_end = is_last && cmd_i.fin && (cmd_i.kind != CMD_OVR);
  assign res_o.overrun    = (cmd_i.kind == CMD_OVR);

  // Advance the step and fold record bytes into the checksum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      crc_q <= '0;
    end else if (emit) begin
      idx_q <= is_last ? 5'd0 : idx_q + 5'd1;
      if (rec_byte) begin
        crc_q <= crc16_byte(crc_base, cur_byte);
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import erf_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 400;
  localparam int RegUnused  = 1;
  localparam int PhaseItems = 85;
  localparam int MaxPrinted = 40;

  // One input item as offered to the block, with an optional typed-in result
  typedef struct packed {
    logic        action;
    logic [15:0] etype;
    logic [31:0] ts;
    logic        save;
    logic [5:0]  plen;
    logic [7:0]  pbyte;
    logic        typed;
    res_t        typed_res;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte_o;
  logic        run_last_o;
  logic        record_end_o;
  logic        overrun_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  stim_t       cur_stim;

  // Framer model state
  logic [15:0] frame_crc;
  logic [5:0]  bytes_left;
  logic [31:0] next_event_id;
  logic        rec_saved;
  logic        rec_open;

  res_t expected_bytes[$];
  res_t item_out[$];
  int   mismatch_count = 0;
  int   result_index = 0;
  int   cycle_count = 0;
  int   items_sent = 0;
  int   burst_left = 0;
  bit   hold_off = 1'b0;

  event_record_framer_crc16 dut (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .action_i         (cur_stim.action),
    .rec_type_i       (cur_stim.etype),
    .timestamp_i      (cur_stim.ts),
    .save_record_i    (cur_stim.save),
    .payload_length_i (cur_stim.plen),
    .payload_byte_i   (cur_stim.pbyte),
    .empty            (empty),
    .pop              (pop),
    .out_byte_o       (out_byte_o),
    .run_last_o       (run_last_o),
    .record_end_o     (record_end_o),
    .overrun_o        (overrun_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // One CRC-16/ARC step over a byte, LSB first
  function automatic logic [15:0] arc_crc_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    return r;
  endfunction

  // Append one framed byte, folding it into the CRC when it belongs to the record
  task automatic put_byte(input logic [7:0] b, input logic in_crc, input logic rend,
                          input logic ovr);
    res_t r;
    if (in_crc) frame_crc = arc_crc_step(frame_crc, b);
    r.out_byte   = b;
    r.run_last   = 1'b0;
    r.record_end = rend;
    r.overrun    = ovr;
    item_out.push_back(r);
  endtask

  // Emit the CRC and close the record
  task automatic close_record();
    put_byte(frame_crc[7:0], 1'b0, 1'b0, 1'b0);
    put_byte(frame_crc[15:8], 1'b0, 1'b1, 1'b0);
    if (rec_saved) next_event_id = next_event_id + 32'd1;
    rec_open   = 1'b0;
    rec_saved  = 1'b0;
    bytes_left = '0;
    frame_crc  = '0;
  endtask

  // Work out the framed bytes one accepted item causes
  task automatic frame_item(input stim_t s);
    logic [5:0]  n;
    logic [15:0] len;
    logic [31:0] eid;
    res_t        last;
    if (s.action == ActHeader) begin
      n   = (s.plen > MaxPayload) ? MaxPayload : s.plen;
      len = {10'd0, n} + HeaderExtra;
      eid = s.save ? next_event_id : 32'd0;
      frame_crc  = '0;
      rec_saved  = s.save;
      rec_open   = 1'b1;
      bytes_left = n;
      put_byte(MagicD, 1'b1, 1'b0, 1'b0);
      put_byte(Magic0, 1'b1, 1'b0, 1'b0);
      put_byte(len[7:0], 1'b1, 1'b0, 1'b0);
      put_byte(len[15:8], 1'b1, 1'b0, 1'b0);
      for (int i = 0; i < 4; i++) put_byte(s.ts[8*i +: 8], 1'b1, 1'b0, 1'b0);
      put_byte(StatusByte, 1'b1, 1'b0, 1'b0);
      for (int i = 0; i < 4; i++) put_byte(eid[8*i +: 8], 1'b1, 1'b0, 1'b0);
      put_byte(s.etype[7:0], 1'b1, 1'b0, 1'b0);
      put_byte(s.etype[15:8], 1'b1, 1'b0, 1'b0);
      if (bytes_left == 0) close_record();
    end else if (!rec_open || bytes_left == 0) begin
      // drop the stray byte
      put_byte(8'h00, 1'b0, 1'b0, 1'b1);
    end else begin
      put_byte(s.pbyte, 1'b1, 1'b0, 1'b0);
      bytes_left = bytes_left - 6'd1;
      if (bytes_left == 0) close_record();
    end
    if (s.typed) begin
      item_out.delete();
      item_out.push_back(s.typed_res);
    end
    last = item_out.pop_back();
    last.run_last = 1'b1;
    item_out.push_back(last);
    foreach (item_out[i]) expected_bytes.push_back(item_out[i]);
    item_out.delete();
  endtask

  // Count each mismatch and print a line for each of the first MaxPrinted
  task automatic flag_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted)
      $display("mismatch on result %0d: %s got %h want %h", result_index, what, got, want);
  endtask

  // Predict on accepted items, check accepted results
  always @(posedge clk) begin
    res_t want;
    if (rst_ni) begin
      if (push && !full) frame_item(cur_stim);
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          flag_mismatch("result with nothing expected, out_byte", out_byte_o, 8'h00);
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte_o !== want.out_byte)
            flag_mismatch("out_byte", out_byte_o, want.out_byte);
          if (run_last_o !== want.run_last)
            flag_mismatch("run_last", {7'd0, run_last_o}, {7'd0, want.run_last});
          if (record_end_o !== want.record_end)
            flag_mismatch("record_end", {7'd0, record_end_o}, {7'd0, want.record_end});
          if (overrun_o !== want.overrun)
            flag_mismatch("overrun", {7'd0, overrun_o}, {7'd0, want.overrun});
        end
        result_index++;
      end
    end
  end

  // Receiver: stall on random stretches, with one long hold-off on request
  initial begin
    int left;
    int pct;
    pop  = 1'b0;
    left = 0;
    pct  = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        hold_off = 1'b0;
        pop <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end else begin
        if (left == 0) begin
          left = $urandom_range(8, 80);
          case ($urandom_range(0, 3))
            0: pct = 0;
            1: pct = 25;
            2: pct = 50;
            default: pct = 80;
          endcase
        end
        left--;
        pop <= ($urandom_range(0, 99) >= pct);
      end
    end
  end

  function automatic stim_t pay_item(input logic [7:0] b);
    stim_t s;
    s        = '0;
    s.action = ActPayload;
    s.etype  = 16'($urandom);
    s.ts     = $urandom;
    s.save   = 1'($urandom);
    s.plen   = 6'($urandom);
    s.pbyte  = b;
    return s;
  endfunction

  function automatic stim_t hdr_item(input logic [15:0] etype, input logic [31:0] ts,
                                     input logic save, input logic [5:0] plen);
    stim_t s;
    s        = '0;
    s.action = ActHeader;
    s.etype  = etype;
    s.ts     = ts;
    s.save   = save;
    s.plen   = plen;
    s.pbyte  = 8'($urandom);
    return s;
  endfunction

  // Stray byte whose single result is known outright
  function automatic stim_t ovr_item(input logic [7:0] b);
    stim_t s;
    s = pay_item(b);
    s.typed                = 1'b1;
    s.typed_res.out_byte   = 8'h00;
    s.typed_res.run_last   = 1'b1;
    s.typed_res.record_end = 1'b0;
    s.typed_res.overrun    = 1'b1;
    return s;
  endfunction

  // Offer one item in bursts with random gaps; entered and left just after a falling edge
  task automatic offer_item(input stim_t s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    push     <= 1'b1;
    cur_stim <= s;
    burst_left--;
    do @(posedge clk); while (full);
    items_sent++;
    @(negedge clk);
  endtask

  // Hold the input until every expected byte has come out
  task automatic drain_results();
    push <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (expected_bytes.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready
  task automatic write_reg(input int idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx * 4);
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == int'(RegStartEventId)) next_event_id = data;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // One random record: mostly well formed, some cut short, some overrun, some stray bytes
  task automatic gen_record(input int fixed_len);
    stim_t s;
    int    pick;
    int    nbytes;
    int    extra;
    int    mode;
    pick = $urandom_range(0, 99);
    if (fixed_len < 0 && pick < 6) begin
      offer_item(pay_item(8'($urandom)));
      return;
    end
    s = hdr_item(16'($urandom), $urandom, 1'($urandom), 6'd0);
    if (fixed_len >= 0) s.plen = 6'(fixed_len);
    else if (pick < 70) s.plen = 6'($urandom_range(0, 8));
    else if (pick < 85) s.plen = 6'($urandom_range(9, 43));
    else if (pick < 93) s.plen = 6'($urandom_range(44, 63));
    else s.plen = MaxPayload;
    nbytes = (s.plen > MaxPayload) ? int'(MaxPayload) : int'(s.plen);
    mode   = (fixed_len >= 0) ? 50 : $urandom_range(0, 99);
    if (mode < 8 && nbytes > 0) nbytes = $urandom_range(0, nbytes - 1);
    extra = (mode >= 92) ? $urandom_range(1, 2) : 0;
    offer_item(s);
    repeat (nbytes + extra) offer_item(pay_item(8'($urandom)));
  endtask

  initial begin
    stim_t       dir_tab[$];
    logic [31:0] phase_ids[4];
    int          target;
    rst_ni   = 1'b0;
    push     = 1'b0;
    cur_stim = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    frame_crc     = '0;
    bytes_left    = '0;
    next_event_id = '0;
    rec_saved     = 1'b0;
    rec_open      = 1'b0;

    // stray byte straight after reset
    dir_tab.push_back(ovr_item(8'h5A));
    // empty saved records, walking the counter across its wrap
    dir_tab.push_back(hdr_item(16'h0000, 32'h0000_0000, 1'b1, 6'd0));
    dir_tab.push_back(hdr_item(16'hFFFF, 32'hFFFF_FFFF, 1'b1, 6'd0));
    // short record, then one byte too many
    dir_tab.push_back(hdr_item(16'h1234, 32'h0000_0005, 1'b0, 6'd3));
    dir_tab.push_back(pay_item(8'h00));
    dir_tab.push_back(pay_item(8'hFF));
    dir_tab.push_back(pay_item(8'hA5));
    dir_tab.push_back(ovr_item(8'h3C));
    // oversized length saturates, then headers abandon open records
    dir_tab.push_back(hdr_item(16'h8001, 32'h8000_0000, 1'b1, 6'd63));
    dir_tab.push_back(pay_item(8'h11));
    dir_tab.push_back(hdr_item(16'h7FFF, 32'h7FFF_FFFF, 1'b1, 6'd2));
    dir_tab.push_back(pay_item(8'h80));
    dir_tab.push_back(hdr_item(16'h00FF, 32'h1234_5678, 1'b0, 6'd1));
    dir_tab.push_back(pay_item(8'h7F));
    dir_tab.push_back(ovr_item(8'h01));
    dir_tab.push_back(hdr_item(16'hABCD, 32'h0000_0000, 1'b0, 6'd43));
    dir_tab.push_back(hdr_item(16'h0001, 32'h0000_0001, 1'b1, 6'd32));
    dir_tab.push_back(hdr_item(16'h0002, 32'h0000_0002, 1'b0, 6'd0));
    dir_tab.push_back(ovr_item(8'hFF));

    phase_ids[0] = 32'h0000_0000;
    phase_ids[1] = 32'hFFFF_FFFF;
    phase_ids[2] = $urandom;
    phase_ids[3] = 32'h8000_0000;

    // reset, then start the counter just below its wrap
    repeat (10) @(negedge clk);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk);
    write_reg(int'(RegStartEventId), 32'hFFFF_FFFE);

    foreach (dir_tab[i]) offer_item(dir_tab[i]);

    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      write_reg(int'(RegStartEventId), phase_ids[ph]);
      if (ph == 2) write_reg(RegUnused, $urandom);
      if (ph == 1) begin
        // long receiver hold-off while a full-size record is offered
        hold_off = 1'b1;
        gen_record(int'(MaxPayload));
      end
      target = items_sent + PhaseItems;
      while (items_sent < target) gen_record(-1);
    end

    drain_results();
    repeat (40) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
